// ----- rtl/core/ilir_pkg.sv -----
// Shared types and codes for the indexed list block.
// Used by ilir_cell, indexed_list_insert_remove and the testbench; depends on nothing.
package ilir_pkg;

	typedef enum logic [2:0] {
		OP_INSERT  = 3'd0,
		OP_REMOVE  = 3'd1,
		OP_SELECT  = 3'd2,
		OP_SEARCH  = 3'd3,
		OP_REPLACE = 3'd4
	} op_e_t;

	// Per-request commands that are broadcast to every cell of the row.
	typedef struct packed {
		logic ins_en;
		logic rem_en;
		logic rep_en;
		logic sel_en;
		logic srch_en;
	} cell_ctrl_t;

endpackage

// ----- rtl/core/ilir_cell.sv -----
// One list cell: holds one entry and shifts it to or from its neighbors.
// Depends on ilir_pkg for the command struct.
module ilir_cell #(
	parameter int IDX        = 0,
	parameter int DATA_WIDTH = 32,
	parameter int CNT_W      = 5
) (
	input  logic                  clk,
	input  ilir_pkg::cell_ctrl_t  ctrl,
	input  logic [CNT_W-1:0]      pos,
	input  logic [CNT_W-1:0]      sel_idx,
	input  logic [CNT_W-1:0]      count,
	input  logic [DATA_WIDTH-1:0] value,
	input  logic [DATA_WIDTH-1:0] left_data,
	input  logic [DATA_WIDTH-1:0] right_data,
	output logic [DATA_WIDTH-1:0] data,
	output logic [DATA_WIDTH-1:0] sel_data,
	output logic                  match
);

	localparam logic [CNT_W-1:0] MyIdx = CNT_W'(IDX);

	logic [DATA_WIDTH-1:0] data_q;

	// Insert moves entries at and after the slot back by one; remove pulls them forward.
	always_ff @(posedge clk) begin
		if (ctrl.ins_en) begin
			if (MyIdx > pos) begin
				data_q <= left_data;
			end else if (MyIdx == pos) begin
				data_q <= value;
			end
		end else if (ctrl.rem_en) begin
			if (MyIdx >= pos) begin
				data_q <= right_data;
			end
		end else if (ctrl.rep_en) begin
			if (MyIdx == pos) begin
				data_q <= value;
			end
		end
	end

	assign data     = data_q;
	assign sel_data = (ctrl.sel_en && (sel_idx == MyIdx)) ? data_q : '0;
	assign match    = ctrl.srch_en && (MyIdx < count) && (data_q == value);

endmodule

// ----- rtl/core/ilir_prio.sv -----
// Priority encoder that turns the registered match vector into a position.
// Standalone; no package items used.
module ilir_prio #(
	parameter int CAPACITY_MAX = 16,
	parameter int CNT_W        = 5
) (
	input  logic [CAPACITY_MAX-1:0] match_vec,
	input  logic [CNT_W-1:0]        miss_idx,
	output logic [CNT_W-1:0]        first_idx
);

	// The lowest matching cell wins; with no match the miss index is returned.
	always_comb begin
		first_idx = miss_idx;
		for (int i = CAPACITY_MAX - 1; i >= 0; i--) begin
			if (match_vec[i]) begin
				first_idx = CNT_W'(i);
			end
		end
	end

endmodule

// ----- rtl/core/indexed_list_insert_remove.sv -----
// Each accepted request is captured in stage 1 and then moves into the output register,
// which happens whenever that register is empty or its result is being taken.
// Throughput: one request per cycle while results are taken; cells update on acceptance.
// A stalled result stays in the output register while one more request waits in stage 1.
// Reset clears the entry count and all valid flags; cell contents are left as they are.
// Depends on ilir_pkg, ilir_cell and ilir_prio.
module indexed_list_insert_remove #(
	parameter int CAPACITY_MAX = 16,
	parameter int DATA_WIDTH   = 32,
	localparam int CNT_W       = $clog2(CAPACITY_MAX + 1)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [2:0]            operation,
	input  logic [CNT_W-1:0]      position,
	input  logic [DATA_WIDTH-1:0] item_value,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic                  ok,
	output logic [DATA_WIDTH-1:0] read_value,
	output logic [CNT_W-1:0]      found_at,
	output logic [CNT_W-1:0]      entry_count,
	output logic                  is_empty,
	output logic                  is_full
);

	localparam logic [CNT_W-1:0] Cap = CNT_W'(CAPACITY_MAX);
	localparam logic [CNT_W-1:0] One = CNT_W'(1);

	// Control state.
	logic             count_q;
	logic [CNT_W-1:0] cnt_q;
	logic             vld_s1;
	logic             out_vld_q;

	// Stage 1 payload.
	logic                    ok_s1;
	logic                    srch_s1;
	logic [DATA_WIDTH-1:0]   rd_s1;
	logic [CAPACITY_MAX-1:0] match_s1;
	logic [CNT_W-1:0]        cnt_s1;

	// Output register payload.
	logic                  ok_q;
	logic [DATA_WIDTH-1:0] rd_q;
	logic [CNT_W-1:0]      found_q;
	logic [CNT_W-1:0]      ecnt_q;

	logic                 acc;
	logic                 s1_adv;
	logic                 ins_ok;
	logic                 rem_ok;
	logic                 rep_ok;
	logic [CNT_W-1:0]     sel_idx;
	logic [CNT_W-1:0]     cnt_nxt;
	logic [CNT_W-1:0]     first_idx;
	ilir_pkg::cell_ctrl_t ctrl;

	logic [DATA_WIDTH-1:0]   cell_data [CAPACITY_MAX];
	logic [DATA_WIDTH-1:0]   cell_sel  [CAPACITY_MAX];
	logic [CAPACITY_MAX-1:0] match_vec;
	logic [DATA_WIDTH-1:0]   sel_word;

	// Stage 1 hands over whenever the output register is empty or being drained,
	// so a new request can enter in the same cycle.
	assign s1_adv   = !out_vld_q || out_ready;
	assign in_ready = !vld_s1 || s1_adv;
	assign acc      = in_valid && in_ready;

	// Legality of each operation is decided against the count before the request.
	assign ins_ok = (operation == ilir_pkg::OP_INSERT) && (position <= cnt_q) && (cnt_q < Cap);
	assign rem_ok = (operation == ilir_pkg::OP_REMOVE) && (position < cnt_q);
	assign rep_ok = (operation == ilir_pkg::OP_REPLACE) && (position < cnt_q);

	// A select past the end reads the last entry; an empty list reads zero because
	// no cell is enabled then.
	assign sel_idx = (position < cnt_q) ? position : (cnt_q - One);

	always_comb begin
		ctrl.ins_en  = acc && ins_ok;
		ctrl.rem_en  = acc && rem_ok;
		ctrl.rep_en  = acc && rep_ok;
		ctrl.sel_en  = (operation == ilir_pkg::OP_SELECT) && (cnt_q != '0);
		ctrl.srch_en = (operation == ilir_pkg::OP_SEARCH);
	end

	always_comb begin
		cnt_nxt = cnt_q;
		if (ins_ok) begin
			cnt_nxt = cnt_q + One;
		end else if (rem_ok) begin
			cnt_nxt = cnt_q - One;
		end
	end

	// The row of cells. Each cell sees its neighbors' entries for shifting.
	for (genvar i = 0; i < CAPACITY_MAX; i++) begin : g_cell
		logic [DATA_WIDTH-1:0] left_w;
		logic [DATA_WIDTH-1:0] right_w;

		if (i == 0) begin : g_first
			assign left_w = '0;
		end else begin : g_left
			assign left_w = cell_data[i-1];
		end

		if (i == CAPACITY_MAX - 1) begin : g_last
			assign right_w = '0;
		end else begin : g_right
			assign right_w = cell_data[i+1];
		end

		ilir_cell #(
			.IDX       (i),
			.DATA_WIDTH(DATA_WIDTH),
			.CNT_W     (CNT_W)
		) u_cell (
			.clk       (clk),
			.ctrl      (ctrl),
			.pos       (position),
			.sel_idx   (sel_idx),
			.count     (cnt_q),
			.value     (item_value),
			.left_data (left_w),
			.right_data(right_w),
			.data      (cell_data[i]),
			.sel_data  (cell_sel[i]),
			.match     (match_vec[i])
		);
	end

	// At most one cell drives a nonzero word, so the read is an OR over the row.
	always_comb begin
		sel_word = '0;
		for (int i = 0; i < CAPACITY_MAX; i++) begin
			sel_word = sel_word | cell_sel[i];
		end
	end

	// The count and the valid flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			vld_s1    <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (acc) begin
				cnt_q <= cnt_nxt;
			end
			if (acc) begin
				vld_s1 <= 1'b1;
			end else if (s1_adv) begin
				vld_s1 <= 1'b0;
			end
			if (s1_adv) begin
				out_vld_q <= vld_s1;
			end
		end
	end

	// Stage 1 captures the per-request outcome and the raw match vector.
	always_ff @(posedge clk) begin
		if (acc) begin
			ok_s1    <= ins_ok || rem_ok || rep_ok;
			srch_s1  <= ctrl.srch_en;
			rd_s1    <= sel_word;
			match_s1 <= match_vec;
			cnt_s1   <= cnt_nxt;
		end
	end

	ilir_prio #(
		.CAPACITY_MAX(CAPACITY_MAX),
		.CNT_W       (CNT_W)
	) u_prio (
		.match_vec(match_s1),
		.miss_idx (cnt_s1),
		.first_idx(first_idx)
	);

	// Output register; found_at is zero for everything but a search.
	always_ff @(posedge clk) begin
		if (s1_adv && vld_s1) begin
			ok_q    <= ok_s1;
			rd_q    <= rd_s1;
			found_q <= srch_s1 ? first_idx : '0;
			ecnt_q  <= cnt_s1;
		end
	end

	assign count_q     = (cnt_q == '0);
	assign out_valid   = out_vld_q;
	assign ok          = ok_q;
	assign read_value  = rd_q;
	assign found_at    = found_q;
	assign entry_count = ecnt_q;
	assign is_empty    = (ecnt_q == '0);
	assign is_full     = (ecnt_q == Cap);

	// The list never holds more entries than its capacity.
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= Cap)
		else $error("entry count exceeds capacity");

	// A successful insert grows the list by exactly one entry.
	a_ins_grow: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && ins_ok) |=> (cnt_q == $past(cnt_q) + One))
		else $error("insert did not grow the list by one");

	// A successful remove shrinks the list by one, and it is empty after removing the last.
	a_rem_shrink: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && rem_ok) |=> ((cnt_q == $past(cnt_q) - One) && (count_q == ($past(cnt_q) == One))))
		else $error("remove did not shrink the list by one");

	// Requests that neither insert nor remove successfully leave the count alone.
	a_cnt_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && !ins_ok && !rem_ok) |=> $stable(cnt_q))
		else $error("count changed on a request that does not resize the list");

	// A search never reports a position beyond the entry count.
	a_found_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q |-> (found_q <= ecnt_q))
		else $error("search position beyond entry count");

endmodule

// ----- dv/indexed_list_checker.sv -----
// Checker for the indexed list block: watches the request and result channels,
// keeps its own copy of the list to predict each result, and counts mismatches.
// Depends on ilir_pkg for the operation codes.
`timescale 1ns / 1ps

module indexed_list_checker #(
	parameter int CAPACITY_MAX = 16,
	parameter int DATA_WIDTH   = 32,
	localparam int CNT_W       = $clog2(CAPACITY_MAX + 1)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic                  in_ready,
	input  logic [2:0]            operation,
	input  logic [CNT_W-1:0]      position,
	input  logic [DATA_WIDTH-1:0] item_value,
	input  logic                  out_valid,
	input  logic                  out_ready,
	input  logic                  ok,
	input  logic [DATA_WIDTH-1:0] read_value,
	input  logic [CNT_W-1:0]      found_at,
	input  logic [CNT_W-1:0]      entry_count,
	input  logic                  is_empty,
	input  logic                  is_full,
	output int                    fail_count,
	output int                    outstanding
);

	typedef struct packed {
		logic                  ok;
		logic [DATA_WIDTH-1:0] read_value;
		logic [CNT_W-1:0]      found_at;
		logic [CNT_W-1:0]      entry_count;
		logic                  is_empty;
		logic                  is_full;
	} list_result_t;

	logic [DATA_WIDTH-1:0] list_words [CAPACITY_MAX];
	int                    list_len;
	list_result_t          pending_results [$];

	// Applies one request to the shadow list and returns the result it should produce.
	function automatic list_result_t predict_list_op(input logic [2:0] op,
			input logic [CNT_W-1:0] pos, input logic [DATA_WIDTH-1:0] val);
		list_result_t r;
		int           i;
		int           p;
		bit           hit;
		r = '0;
		hit = 1'b0;
		p = int'(pos);
		case (op)
			ilir_pkg::OP_INSERT: begin
				if (p <= list_len && list_len < CAPACITY_MAX) begin
					for (i = list_len; i > p; i--)
						list_words[i] = list_words[i - 1];
					list_words[p] = val;
					list_len++;
					r.ok = 1'b1;
				end
			end
			ilir_pkg::OP_REMOVE: begin
				if (p < list_len) begin
					for (i = p; i + 1 < list_len; i++)
						list_words[i] = list_words[i + 1];
					list_len--;
					r.ok = 1'b1;
				end
			end
			ilir_pkg::OP_SELECT: begin
				if (list_len > 0)
					r.read_value = (p < list_len) ? list_words[p] : list_words[list_len - 1];
			end
			ilir_pkg::OP_SEARCH: begin
				r.found_at = CNT_W'(list_len);
				for (i = 0; i < list_len; i++) begin
					if (!hit && list_words[i] == val) begin
						r.found_at = CNT_W'(i);
						hit = 1'b1;
					end
				end
			end
			ilir_pkg::OP_REPLACE: begin
				if (p < list_len) begin
					list_words[p] = val;
					r.ok = 1'b1;
				end
			end
			default: begin
			end
		endcase
		r.entry_count = CNT_W'(list_len);
		r.is_empty = (list_len == 0);
		r.is_full = (list_len == CAPACITY_MAX);
		return r;
	endfunction

	task automatic report_field(input string field, input longint unsigned want,
			input longint unsigned got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0h actual %0h", $time, field, want, got);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		list_result_t want;
		if (!arst_n) begin
			list_len = 0;
			pending_results.delete();
			outstanding = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (pending_results.size() == 0) begin
					$display("%0t: result with none expected, expected none actual ok=%0d rd=%0h",
						$time, ok, read_value);
					fail_count++;
				end else begin
					want = pending_results.pop_front();
					report_field("ok", want.ok, ok);
					report_field("read_value", want.read_value, read_value);
					report_field("found_at", want.found_at, found_at);
					report_field("entry_count", want.entry_count, entry_count);
					report_field("is_empty", want.is_empty, is_empty);
					report_field("is_full", want.is_full, is_full);
				end
			end
			if (in_valid && in_ready)
				pending_results.push_back(predict_list_op(operation, position, item_value));
			outstanding = pending_results.size();
		end
	end

	initial begin
		fail_count = 0;
		outstanding = 0;
		list_len = 0;
	end

endmodule

// ----- dv/indexed_list_insert_remove_test.sv -----
// Top of the indexed list testbench: clock, reset, request stimulus and verdict.
// Depends on ilir_pkg, indexed_list_insert_remove and indexed_list_checker.
`timescale 1ns / 1ps

module indexed_list_insert_remove_test;

	localparam int CAPACITY_MAX = 16;
	localparam int DATA_WIDTH   = 32;
	localparam int CNT_W        = $clog2(CAPACITY_MAX + 1);
	// Codes five to seven are unused by the block; they must leave the list untouched.
	localparam logic [2:0] OP_UNUSED_FIRST = 3'd5;
	localparam logic [2:0] OP_UNUSED_LAST  = 3'd7;
	localparam int PHASE_ITEMS  = 260;
	localparam int DRAIN_CYCLES = 10;
	localparam int RUN_LIMIT    = 200000;

	logic                  clk;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic [2:0]            operation = '0;
	logic [CNT_W-1:0]      position = '0;
	logic [DATA_WIDTH-1:0] item_value = '0;
	logic                  out_ready = 1'b0;
	logic                  in_ready;
	logic                  out_valid;
	logic                  ok;
	logic [DATA_WIDTH-1:0] read_value;
	logic [CNT_W-1:0]      found_at;
	logic [CNT_W-1:0]      entry_count;
	logic                  is_empty;
	logic                  is_full;

	int fail_count;
	int outstanding;

	// Idle percentages of the current phase, for the request side and the result side.
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int send_phase_pct [4] = '{0, 65, 0, 37};
	int recv_phase_pct [4] = '{0, 0, 65, 37};

	// The stimulus keeps a rough fill level of the list so that positions can be
	// aimed at the live range; it also decides whether the random part is filling
	// the list toward full or draining it toward empty.
	int fill_level = 0;
	bit filling = 1'b1;
	// A small pool of words makes duplicates common, so that a search often hits
	// and the first-match rule is exercised.
	logic [DATA_WIDTH-1:0] value_pool [8];
	longint cycle_count = 0;

	indexed_list_insert_remove #(
		.CAPACITY_MAX(CAPACITY_MAX),
		.DATA_WIDTH  (DATA_WIDTH)
	) dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.operation  (operation),
		.position   (position),
		.item_value (item_value),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.ok         (ok),
		.read_value (read_value),
		.found_at   (found_at),
		.entry_count(entry_count),
		.is_empty   (is_empty),
		.is_full    (is_full)
	);

	indexed_list_checker #(
		.CAPACITY_MAX(CAPACITY_MAX),
		.DATA_WIDTH  (DATA_WIDTH)
	) checker_i (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.operation  (operation),
		.position   (position),
		.item_value (item_value),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.ok         (ok),
		.read_value (read_value),
		.found_at   (found_at),
		.entry_count(entry_count),
		.is_empty   (is_empty),
		.is_full    (is_full),
		.fail_count (fail_count),
		.outstanding(outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// The result side stalls at random with the percentage of the current phase.
	always @(posedge clk) begin
		if (arst_n)
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// Hard stop in case the block hangs on either channel.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > RUN_LIMIT) begin
			$display("indexed_list_insert_remove test failed");
			$finish;
		end
	end

	// Presents one request and returns at the edge that accepts it. Valid is only
	// dropped when an idle gap is inserted, so it never falls and rises in one step.
	task automatic send_request(input logic [2:0] op, input logic [CNT_W-1:0] pos,
			input logic [DATA_WIDTH-1:0] val);
		if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(99) < send_idle_pct);
		end
		in_valid <= 1'b1;
		operation <= op;
		position <= pos;
		item_value <= val;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		// Follow the fill level so the next positions land in or near the live range.
		if (op == ilir_pkg::OP_INSERT && pos <= fill_level && fill_level < CAPACITY_MAX)
			fill_level++;
		else if (op == ilir_pkg::OP_REMOVE && pos < fill_level)
			fill_level--;
	endtask

	// Builds one random request. Most requests are well aimed at the current list;
	// a few are pure noise over the whole width of every field.
	task automatic random_request();
		logic [2:0]            op;
		logic [CNT_W-1:0]      pos;
		logic [DATA_WIDTH-1:0] val;
		int                    pick;
		// Turn around at the ends after a while, so that inserts into a full list
		// and removes from an empty one also occur; now and then turn mid-way.
		if (fill_level == CAPACITY_MAX && $urandom_range(99) < 25)
			filling = 1'b0;
		else if (fill_level == 0 && $urandom_range(99) < 25)
			filling = 1'b1;
		else if ($urandom_range(99) < 2)
			filling = !filling;
		if ($urandom_range(99) < 8) begin
			op = 3'($urandom_range(7));
			pos = CNT_W'($urandom_range(31));
			val = DATA_WIDTH'($urandom());
		end else begin
			pick = $urandom_range(99);
			if (pick < 45)
				op = filling ? ilir_pkg::OP_INSERT : ilir_pkg::OP_REMOVE;
			else if (pick < 55)
				op = filling ? ilir_pkg::OP_REMOVE : ilir_pkg::OP_INSERT;
			else if (pick < 70)
				op = ilir_pkg::OP_SELECT;
			else if (pick < 85)
				op = ilir_pkg::OP_SEARCH;
			else
				op = ilir_pkg::OP_REPLACE;
			if ($urandom_range(9) == 0)
				pos = CNT_W'($urandom_range(CAPACITY_MAX));
			else if (op == ilir_pkg::OP_INSERT)
				pos = CNT_W'($urandom_range(fill_level));
			else
				pos = (fill_level == 0) ? '0 : CNT_W'($urandom_range(fill_level - 1));
			case ($urandom_range(3))
				0, 1: val = value_pool[3'($urandom_range(7))];
				2: val = DATA_WIDTH'($urandom());
				default: val = $urandom_range(1) ? '1 : '0;
			endcase
		end
		send_request(op, pos, val);
	endtask

	initial begin
		for (int i = 0; i < 8; i++)
			value_pool[i] = DATA_WIDTH'($urandom());
		value_pool[0] = '0;
		value_pool[1] = '1;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed opening, all with both channels running freely. Every failing
		// form is tried first on the empty list.
		send_request(ilir_pkg::OP_REMOVE, 0, 32'h1111_1111);
		send_request(ilir_pkg::OP_SELECT, 0, '0);
		send_request(ilir_pkg::OP_SEARCH, 0, '0);
		send_request(ilir_pkg::OP_REPLACE, 0, 32'h2222_2222);
		send_request(ilir_pkg::OP_INSERT, 1, 32'h3333_3333);
		// Build a short list: head insert, append at the end and a middle insert.
		send_request(ilir_pkg::OP_INSERT, 0, '0);
		send_request(ilir_pkg::OP_INSERT, 1, '1);
		send_request(ilir_pkg::OP_INSERT, 1, 32'hA5A5_A5A5);
		// A select past the end returns the last entry, even at the largest position.
		send_request(ilir_pkg::OP_SELECT, 31, '0);
		send_request(ilir_pkg::OP_SELECT, 1, '0);
		send_request(ilir_pkg::OP_SEARCH, 0, '1);
		send_request(ilir_pkg::OP_SEARCH, 0, 32'h1234_5678);
		send_request(ilir_pkg::OP_REPLACE, 0, 32'h5A5A_5A5A);
		send_request(ilir_pkg::OP_REPLACE, 3, 32'h4444_4444);
		send_request(ilir_pkg::OP_REMOVE, 1, '0);
		send_request(ilir_pkg::OP_REMOVE, 5, '0);
		send_request(OP_UNUSED_FIRST, 0, 32'h6666_6666);
		send_request(OP_UNUSED_LAST, 31, '1);
		// A duplicate word: the search must report the first occurrence.
		send_request(ilir_pkg::OP_INSERT, 0, '1);
		send_request(ilir_pkg::OP_SEARCH, 0, '1);
		send_request(ilir_pkg::OP_REMOVE, 2, '0);
		send_request(ilir_pkg::OP_REMOVE, 0, '0);
		send_request(ilir_pkg::OP_REMOVE, 0, '0);
		send_request(ilir_pkg::OP_SELECT, 16, '0);

		// Random part in four idling phases: none, sender idle, receiver stalling, both.
		for (int phase = 0; phase < 4; phase++) begin
			send_idle_pct = send_phase_pct[phase];
			recv_stall_pct = recv_phase_pct[phase];
			for (int n = 0; n < PHASE_ITEMS; n++)
				random_request();
		end
		in_valid <= 1'b0;

		// Check at the falling edge so the checker has settled the accepting edge.
		do
			@(negedge clk);
		while (outstanding != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (fail_count == 0 && outstanding == 0)
			$display("indexed_list_insert_remove test passed");
		else
			$display("indexed_list_insert_remove test failed");
		$finish;
	end

endmodule

// ----- filelist.f -----
rtl/core/ilir_pkg.sv
rtl/core/ilir_cell.sv
rtl/core/ilir_prio.sv
rtl/core/indexed_list_insert_remove.sv
dv/indexed_list_checker.sv
dv/indexed_list_insert_remove_test.sv
